>>> rtl/scsas_pkg.sv
// Package for the sign-chain sketch anomaly scorer.
// Shared constants and parameter defaults; no dependencies.
package scsas_pkg;

    localparam int NUM_MAPS      = 4;
    localparam int MAP_W         = 32;
    localparam int NIB_W         = 4;
    localparam int NIB_PER_MAP   = MAP_W / NIB_W;
    localparam int SIGN_W        = 16;
    localparam int SCORE_W       = 14;
    localparam int FRAC_W        = 8;
    localparam int CFG_AW        = 4;

    localparam int DEF_CHAINS     = 4;
    localparam int DEF_LEVELS     = 8;
    localparam int DEF_FEATURES   = 16;
    localparam int DEF_COUNT_BITS = 32;

endpackage

>>> rtl/sign_chain_sketch_anomaly_score.sv
// Top level of the sign-chain sketch anomaly scorer.
// Depends on scsas_pkg.
//
// Takes one item per cycle while neither a stalled output nor the clearing pass
// holds it back, and returns one score per item. Every (chain, level) pair has
// its own counter memory, so all counters an item touches are read, incremented
// and written back in a single pass; back-to-back hits on the same entry are
// forwarded from the last write. After reset a clearing pass zeroes all counters,
// during which no item is taken; configuration writes are taken as usual.
module sign_chain_sketch_anomaly_score
    import scsas_pkg::*;
#(
    parameter int CHAINS     = DEF_CHAINS,
    parameter int LEVELS     = DEF_LEVELS,
    parameter int FEATURES   = DEF_FEATURES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [MAP_W-1:0]    pwdata,
    output logic [MAP_W-1:0]    prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SIGN_W-1:0]   sign_bits,
    input  logic                count_enable,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SCORE_W-1:0]  anomaly_score
);

    localparam int MI_W    = $clog2(NUM_MAPS);
    localparam int CW      = COUNT_BITS + 1;
    localparam int P_W     = 6;
    localparam int SUM_W   = SCORE_W + $clog2(CHAINS + 1);
    localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'((1 << SUM_W) / CHAINS);
    localparam logic [SUM_W+3:0] CH_W = (SUM_W + 4)'(CHAINS);
    localparam int CLR_W   = LEVELS + 1;

    // configuration
    logic [MAP_W-1:0] map_reg [NUM_MAPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MAPS; i++)
                map_reg[i] <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            map_reg[paddr[MI_W+1:2]] <= pwdata;
        end
    end

    assign prdata = map_reg[paddr[MI_W+1:2]];
    assign pready = 1'b1;

    // clearing pass
    logic             clearing_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_W'((1 << LEVELS) - 1))
                clearing_reg <= 1'b0;
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic en1, en2, en3, en4, en5, en_o;
    logic accept, wr_en;

    assign en_o     = !vo_reg || out_ready;
    assign en5      = !v5_reg || en_o;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1 && !clearing_reg;
    assign accept   = in_valid && in_ready;
    assign wr_en    = v1_reg && en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)  v1_reg <= accept;
            if (en2)  v2_reg <= v1_reg;
            if (en3)  v3_reg <= v2_reg;
            if (en4)  v4_reg <= v3_reg;
            if (en5)  v5_reg <= v4_reg;
            if (en_o) vo_reg <= v5_reg;
        end
    end

    // key selection
    logic [NIB_W-1:0]  mod_tbl [1 << NIB_W];
    logic [MAP_W-1:0]  cmap    [CHAINS];
    logic [LEVELS-1:0] key0    [CHAINS];
    logic [LEVELS-1:0] key1_reg [CHAINS];
    logic              cen1_reg;
    logic [COUNT_BITS-1:0] cnt_new  [CHAINS][LEVELS];
    logic [COUNT_BITS-1:0] cnt2_reg [CHAINS][LEVELS];

    for (genvar i = 0; i < (1 << NIB_W); i++)
    begin : g_mod
        assign mod_tbl[i] = NIB_W'(i % FEATURES);
    end

    for (genvar c = 0; c < CHAINS; c++)
    begin : g_chain
        if (c < NUM_MAPS)
        begin : g_map
            assign cmap[c] = map_reg[c];
        end
        else
        begin : g_nomap
            assign cmap[c] = '0;
        end

        for (genvar d = 0; d < LEVELS; d++)
        begin : g_level
            localparam int DEPTH = 1 << (d + 1);
            logic [NIB_W-1:0] nib;
            logic [COUNT_BITS-1:0] mem [DEPTH];
            logic [COUNT_BITS-1:0] rdata_reg;
            logic [d:0]            lw_key_reg;
            logic [COUNT_BITS-1:0] lw_val_reg;
            logic                  lw_vld_reg;
            logic [COUNT_BITS-1:0] cur;

            if (d < NIB_PER_MAP)
            begin : g_nib
                assign nib = cmap[c][NIB_W*d +: NIB_W];
            end
            else
            begin : g_zero
                assign nib = '0;
            end

            assign key0[c][d] = sign_bits[mod_tbl[nib]];

            assign cur = (lw_vld_reg && lw_key_reg == key1_reg[c][d:0]) ? lw_val_reg
                                                                        : rdata_reg;
            assign cnt_new[c][d] = (cen1_reg && cur != {COUNT_BITS{1'b1}}) ? cur + 1'b1
                                                                            : cur;

            always_ff @(posedge clk)
            begin
                if (clearing_reg)
                    mem[clr_cnt_reg[d:0]] <= '0;
                else if (wr_en)
                    mem[key1_reg[c][d:0]] <= cnt_new[c][d];
                if (accept)
                    rdata_reg <= mem[key0[c][d:0]];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    lw_vld_reg <= 1'b0;
                else if (clearing_reg)
                    lw_vld_reg <= 1'b0;
                else if (wr_en)
                    lw_vld_reg <= 1'b1;
            end

            always_ff @(posedge clk)
            begin
                if (wr_en)
                begin
                    lw_key_reg <= key1_reg[c][d:0];
                    lw_val_reg <= cnt_new[c][d];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key1_reg <= key0;
            cen1_reg <= count_enable;
        end
        if (en2)
            cnt2_reg <= cnt_new;
    end

    // log2 and chain minimum
    logic [SCORE_W-1:0] min_next [CHAINS];
    logic [SCORE_W-1:0] min3_reg [CHAINS];

    always_comb
    begin
        logic [CW-1:0]          v;
        logic [P_W-1:0]         p;
        logic [CW+FRAC_W-1:0]   ext;
        logic [SCORE_W-1:0]     sc;
        for (int c = 0; c < CHAINS; c++)
        begin
            min_next[c] = '1;
            for (int d = 0; d < LEVELS; d++)
            begin
                v = {1'b0, cnt2_reg[c][d]} + 1'b1;
                p = '0;
                for (int i = 0; i < CW; i++)
                    if (v[i])
                        p = P_W'(i);
                ext = {v, {FRAC_W{1'b0}}} >> p;
                sc  = {P_W'(p + P_W'(d + 1)), ext[FRAC_W-1:0]};
                if (sc < min_next[c])
                    min_next[c] = sc;
            end
        end
    end

    // average
    logic [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]   sum4_reg;
    logic [2*SUM_W:0]   prod;
    logic [SUM_W-1:0]   q5_reg;
    logic [SUM_W-1:0]   sum5_reg;
    logic [SUM_W+3:0]   rem;
    logic [SUM_W-1:0]   q_next;
    logic [SCORE_W-1:0] score_reg;

    always_comb
    begin
        sum_next = '0;
        for (int c = 0; c < CHAINS; c++)
            sum_next = sum_next + SUM_W'(min3_reg[c]);
    end

    assign prod   = (2*SUM_W+1)'(sum4_reg) * (2*SUM_W+1)'(RECIP);
    assign rem    = (SUM_W+4)'(sum5_reg) - (SUM_W+4)'(q5_reg) * CH_W;
    assign q_next = (rem >= CH_W) ? q5_reg + 1'b1 : q5_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
            min3_reg <= min_next;
        if (en4)
            sum4_reg <= sum_next;
        if (en5)
        begin
            q5_reg   <= prod[2*SUM_W-1:SUM_W];
            sum5_reg <= sum4_reg;
        end
        if (en_o)
            score_reg <= q_next[SCORE_W-1:0];
    end

    assign out_valid     = vo_reg;
    assign anomaly_score = score_reg;

endmodule

>>> tb/tb_sign_chain_sketch_anomaly_score.sv
// Testbench for the sign-chain sketch anomaly scorer: drives items, programs the feature
// maps over APB and checks every score against an in-bench counter table predictor.
// Depends on scsas_pkg and sign_chain_sketch_anomaly_score.
module tb_sign_chain_sketch_anomaly_score;
    import scsas_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAINS    = DEF_CHAINS;
    localparam int LEVELS    = DEF_LEVELS;
    localparam int FEATURES  = DEF_FEATURES;
    localparam int CNT_W     = DEF_COUNT_BITS;
    localparam int SPAN      = (1 << (LEVELS + 1)) - 2;
    localparam int TBL       = CHAINS * SPAN;
    localparam int WD_LIMIT  = 20000;
    localparam int SETTLE    = 16;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CFG_AW-1:0]   paddr = '0;
    logic [MAP_W-1:0]    pwdata = '0;
    logic [MAP_W-1:0]    prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [SIGN_W-1:0]   sign_bits = '0;
    logic                count_enable = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [SCORE_W-1:0]  anomaly_score;

    sign_chain_sketch_anomaly_score dut (.*);

    logic [MAP_W-1:0]    fmap [NUM_MAPS];
    logic [CNT_W-1:0]    sketch [TBL];
    logic [SCORE_W-1:0]  score_q [$];
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    bit                  hold_off = 1'b0;
    int                  mismatches = 0;
    int                  scores_seen = 0;
    int                  items_sent = 0;
    int                  idle_cycles = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [15:0] mitchell_q8(input logic [CNT_W:0] v);
        int p;
        logic [7:0] frac;
        p = 0;
        for (int i = 0; i <= CNT_W; i++)
            if (v[i])
                p = i;
        if (p >= 8)
            frac = 8'(v >> (p - 8));
        else
            frac = 8'(v << (8 - p));
        return 16'((p << 8) | frac);
    endfunction

    function automatic logic [SCORE_W-1:0] score_item(input logic [SIGN_W-1:0] s,
                                                      input logic en);
        logic [31:0] sum;
        logic [31:0] best;
        logic [31:0] lvl;
        logic [31:0] key;
        int          feat;
        int          addr;
        logic [CNT_W-1:0] cnt;
        sum = 0;
        for (int c = 0; c < CHAINS; c++)
        begin
            key = 0;
            best = 0;
            for (int d = 0; d < LEVELS; d++)
            begin
                feat = (d < NIB_PER_MAP && c < NUM_MAPS) ? int'(fmap[c][4*d +: 4]) : 0;
                feat = feat % FEATURES;
                if (feat < SIGN_W)
                    key[d] = s[feat];
                addr = c * SPAN + ((1 << (d + 1)) - 2) + int'(key);
                cnt = sketch[addr];
                if (en && cnt != '1)
                begin
                    cnt = cnt + 1'b1;
                    sketch[addr] = cnt;
                end
                lvl = mitchell_q8({1'b0, cnt} + 1) + ((d + 1) << 8);
                if (d == 0 || lvl < best)
                    best = lvl;
            end
            sum = sum + best;
        end
        return SCORE_W'(sum / CHAINS);
    endfunction

    task automatic apb_write(input int idx, input logic [MAP_W-1:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= CFG_AW'(4 * idx);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        fmap[idx] = val;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (score_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_item(input logic [SIGN_W-1:0] s, input logic en);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        sign_bits <= s;
        count_enable <= en;
        do
            @(posedge clk);
        while (!in_ready);
        score_q.insert(score_q.size(), score_item(s, en));
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            scores_seen++;
            if (score_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected score %0d with none pending", anomaly_score);
            end
            else
            begin
                logic [SCORE_W-1:0] want;
                want = score_q.pop_front();
                if (want !== anomaly_score)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("score mismatch: expected %0d got %0d", want, anomaly_score);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic rand_maps();
        for (int i = 0; i < NUM_MAPS; i++)
            apb_write(i, $urandom());
    endtask

    task automatic test_directed();
        send_item('0, 1'b0);
        send_item('0, 1'b1);
        send_item('1, 1'b1);
        send_item('1, 1'b0);
        wait_drained();
        apb_write(0, 32'hFFFF_FFFF);
        apb_write(1, 32'h7654_3210);
        apb_write(2, 32'hFEDC_BA98);
        apb_write(3, 32'h0F0F_0F0F);
        for (int i = 0; i < 16; i++)
            send_item(16'(1 << i), 1'(i % 3 != 0));
        send_item(16'hAAAA, 1'b1);
        send_item(16'h5555, 1'b1);
        send_item(16'hFFFF, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int n);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                send_item(16'($urandom_range(3) << ($urandom_range(14))),
                          1'($urandom_range(1)));
            else
                send_item(16'($urandom()), $urandom_range(4) != 0);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 60; i++)
                send_item(16'($urandom()), 1'b1);
        join
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < NUM_MAPS; i++)
            fmap[i] = '0;
        for (int i = 0; i < TBL; i++)
            sketch[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        rand_maps();
        test_random_phase(0, 0, 450);
        apb_write(0, 32'h0000_0000);
        apb_write(3, 32'hFFFF_FFFF);
        test_random_phase(48, 0, 450);
        rand_maps();
        test_random_phase(0, 48, 450);
        apb_write(1, 32'h3333_3333);
        test_random_phase(14, 14, 450);
        test_backpressure();
        $display("Sent %0d items, checked %0d scores over idle/stall phases and a long stall.",
                 items_sent, scores_seen);
        $display("Feature maps covered all-zero, all-ones, sequential and random settings.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
